// ----- design/voice_gate_episode_alarm_defines.svh -----
// ----------------------------------------------------------------------------
// Voice gate episode alarm: assertion macros
// Shared concurrent assertion forms for the checker of the alarm block.
// ----------------------------------------------------------------------------
`ifndef VOICE_GATE_EPISODE_ALARM_DEFINES_SVH
`define VOICE_GATE_EPISODE_ALARM_DEFINES_SVH

// Overlapping implication, sampled on the rising clock, idle in reset.
`define VGEA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Implication that checks its consequent in the cycle after the antecedent.
`define VGEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/vgea_pkg.sv -----
// ----------------------------------------------------------------------------
// Voice gate episode alarm: package
// Widths, register indexes, result codes and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package vgea_pkg;

    localparam int RMS_W      = 16;
    localparam int PROB_W     = 16;
    localparam int GAIN_W     = 8;
    localparam int RUN_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = RMS_W + GAIN_W;

    localparam int HISTORY_DEPTH_DEF = 8;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    // Output beat layout, lowest bit up
    localparam int OUT_BLINK_LSB  = 0;
    localparam int OUT_VOICE_LSB  = 2;
    localparam int OUT_STATUS_LSB = 3;
    localparam int OUT_GATE_LSB   = 5;
    localparam int OUT_USED_W     = 21;

    localparam logic [RMS_W-1:0] RMS_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_FLOOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR_CAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MALE_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MALE_NEEDED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_NEEDED   = 3'd5;

    // Register reset values
    localparam logic [RMS_W-1:0]  RST_SILENCE_FLOOR   = 16'd655;
    localparam logic [RMS_W-1:0]  RST_NOISE_FLOOR_CAP = 16'd6554;
    localparam logic [GAIN_W-1:0] RST_FLOOR_GAIN      = 8'd48;
    localparam logic [PROB_W-1:0] RST_MALE_THRESHOLD  = 16'd32768;
    localparam logic [RUN_W-1:0]  RST_MALE_NEEDED     = 8'd3;
    localparam logic [RUN_W-1:0]  RST_NORMAL_NEEDED   = 8'd3;

    // Blink event codes
    localparam logic [1:0] BLINK_NONE  = 2'd0;
    localparam logic [1:0] BLINK_GREEN = 2'd1;
    localparam logic [1:0] BLINK_RED   = 2'd2;

    // Class status codes
    localparam logic [1:0] STAT_SILENCE   = 2'd0;
    localparam logic [1:0] STAT_NORMAL    = 2'd1;
    localparam logic [1:0] STAT_UNCERTAIN = 2'd2;
    localparam logic [1:0] STAT_ANOMALY   = 2'd3;

    typedef struct packed {
        logic [PROB_W-1:0] male_threshold;
        logic [RUN_W-1:0]  male_needed;
        logic [RUN_W-1:0]  normal_needed;
    } t_ep_cfg;

    typedef struct packed {
        logic [1:0] blink;
        logic [1:0] status;
    } t_ep_result;

endpackage

`default_nettype wire

// ----- design/vgea_cell.sv -----
// ----------------------------------------------------------------------------
// Voice gate episode alarm: history cell
// Holds the minimum over the newest entries up to its place in the row.
// ----------------------------------------------------------------------------
`default_nettype none

module vgea_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_shift,
    input  wire logic [vgea_pkg::RMS_W-1:0] i_rms,
    input  wire logic [vgea_pkg::RMS_W-1:0] i_prev_min,
    output logic      [vgea_pkg::RMS_W-1:0] o_min
);

    logic [vgea_pkg::RMS_W-1:0] r_min;
    logic [vgea_pkg::RMS_W-1:0] n_min;

    // Entry slides one place; new window joins every prefix.
    assign n_min = (i_rms < i_prev_min) ? i_rms : i_prev_min;

    // Unwritten places read as full scale, neutral for a minimum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= vgea_pkg::RMS_MAX;
        end else if (i_shift) begin
            r_min <= n_min;
        end
    end

    assign o_min = r_min;

endmodule

`default_nettype wire

// ----- design/vgea_episode.sv -----
// ----------------------------------------------------------------------------
// Voice gate episode alarm: debounce and episode tracker
// Run counters and the none/normal/anomaly episode machine.
// ----------------------------------------------------------------------------
`default_nettype none

module vgea_episode (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire logic                        i_voice,
    input  wire logic [vgea_pkg::PROB_W-1:0] i_prob,
    input  wire vgea_pkg::t_ep_cfg           i_cfg,
    output vgea_pkg::t_ep_result             o_result
);

    typedef enum logic [1:0] {
        M_NONE,
        M_NORMAL,
        M_ANOMALY
    } t_mode;

    t_mode                      r_mode, n_mode;
    logic [vgea_pkg::RUN_W-1:0] r_male_run, n_male_run;
    logic [vgea_pkg::RUN_W-1:0] r_normal_run, n_normal_run;
    logic                       w_male, w_male_ok, w_normal_ok;

    always_comb begin
        w_male       = (i_prob > i_cfg.male_threshold);
        n_male_run   = '0;
        n_normal_run = '0;
        n_mode       = M_NONE;
        o_result.blink  = vgea_pkg::BLINK_NONE;
        o_result.status = vgea_pkg::STAT_SILENCE;
        w_male_ok    = 1'b0;
        w_normal_ok  = 1'b0;
        if (i_voice) begin
            // Advance one run, saturating, and drop the other
            if (w_male) begin
                n_male_run = (r_male_run == '1) ? r_male_run
                                                : r_male_run + 1'b1;
            end else begin
                n_normal_run = (r_normal_run == '1) ? r_normal_run
                                                    : r_normal_run + 1'b1;
            end
            w_male_ok   = (n_male_run >= i_cfg.male_needed);
            w_normal_ok = (n_normal_run >= i_cfg.normal_needed);
            n_mode      = r_mode;
            if (w_male_ok && (r_mode != M_ANOMALY)) begin
                o_result.blink = vgea_pkg::BLINK_RED;
                n_mode         = M_ANOMALY;
            end else if (w_normal_ok) begin
                if (r_mode == M_NONE) begin
                    o_result.blink = vgea_pkg::BLINK_GREEN;
                    n_mode         = M_NORMAL;
                end else if (r_mode == M_ANOMALY) begin
                    // Re-arm red after a confirmed normal voice
                    n_mode = M_NORMAL;
                end
            end
            if (w_male_ok) begin
                o_result.status = vgea_pkg::STAT_ANOMALY;
            end else if (n_male_run != '0) begin
                o_result.status = vgea_pkg::STAT_UNCERTAIN;
            end else begin
                o_result.status = vgea_pkg::STAT_NORMAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_NONE;
            r_male_run   <= '0;
            r_normal_run <= '0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_male_run   <= n_male_run;
            r_normal_run <= n_normal_run;
        end
    end

endmodule

`default_nettype wire

// ----- design/voice_gate_episode_alarm.sv -----
// ----------------------------------------------------------------------------
// Voice gate episode alarm: top level
// Adaptive silence gate over recent window levels, debounced voice class
// and at most one LED blink event per normal or anomaly episode.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat fields (lowest bit up)
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   window_rms[15:0], male_probability[31:16]
//  m_axis    out  blink_event[1:0], voice_present[2], class_status[4:3],
//                 gate_level[20:5], zero fill [23:21]
//  i_cfg_*   in   register index, data; one write per cycle with i_cfg_we
//
//  A window passes four steps: accept, gain multiply, gate, decide. The gate
//  path (one 8x16 multiply, then clamp and compare) sets that split.
//  The decide step waits while the output register still holds a beat that
//  has not been taken. Reset is synchronous and active low; it restores all
//  register defaults, clears the run counters and the episode, and marks the
//  whole history row as unwritten. No clearing pass is needed.
//
`default_nettype none

module voice_gate_episode_alarm #(
    parameter int HISTORY_DEPTH = vgea_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // window_rms [15:0], male_probability [31:16]
    input  wire logic [vgea_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // blink_event [1:0], voice_present [2], class_status [4:3],
    // gate_level [20:5], zero [23:21]
    output logic      [vgea_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             i_cfg_we,
    input  wire logic [vgea_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [vgea_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int RW = vgea_pkg::RMS_W;
    localparam int PW = vgea_pkg::PROD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_GATE,
        S_DECIDE
    } t_state;

    // Configuration registers
    logic [RW-1:0]                   r_silence_floor;
    logic [RW-1:0]                   r_noise_cap;
    logic [vgea_pkg::GAIN_W-1:0]     r_floor_gain;
    vgea_pkg::t_ep_cfg               r_ep_cfg;

    t_state                          r_state;
    logic [RW-1:0]                   r_rms;
    logic [vgea_pkg::PROB_W-1:0]     r_prob;
    logic [PW-1:0]                   r_prod;
    logic [RW-1:0]                   r_gate;
    logic                            r_out_valid;
    logic [vgea_pkg::OUT_USED_W-1:0] r_out_data;

    logic                            w_accept;
    logic                            w_out_free;
    logic                            w_step;
    logic                            w_voice;
    logic [RW-1:0]                   w_floor;
    logic [RW-1:0]                   w_prod_sat;
    logic [RW-1:0]                   w_min [HISTORY_DEPTH];
    vgea_pkg::t_ep_result            w_ep_result;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = (r_state == S_DECIDE) && w_out_free;

    // ---- history row: cell i holds the minimum of the newest i+1 windows
    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                vgea_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_shift    (w_accept),
                    .i_rms      (s_axis_tdata[RW-1:0]),
                    .i_prev_min (vgea_pkg::RMS_MAX),
                    .o_min      (w_min[gi])
                );
            end else begin : g_body
                vgea_cell u_cell (
                    .i_clk      (i_clk),
                    .i_rst_n    (i_rst_n),
                    .i_shift    (w_accept),
                    .i_rms      (s_axis_tdata[RW-1:0]),
                    .i_prev_min (w_min[gi-1]),
                    .o_min      (w_min[gi])
                );
            end
        end
    endgenerate

    // ---- gate arithmetic: the tail cell holds the window-set minimum
    assign w_floor = (w_min[HISTORY_DEPTH-1] > r_noise_cap) ? r_noise_cap
                                                            : w_min[HISTORY_DEPTH-1];
    // Q4.4 gain: drop four fraction bits, saturate to 16 bits
    assign w_prod_sat = (|r_prod[PW-1:RW+4]) ? vgea_pkg::RMS_MAX : r_prod[RW+3:4];
    assign w_voice    = (r_rms >= r_gate);

    vgea_episode u_episode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_voice  (w_voice),
        .i_prob   (r_prob),
        .i_cfg    (r_ep_cfg),
        .o_result (w_ep_result)
    );

    // ---- configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_silence_floor         <= vgea_pkg::RST_SILENCE_FLOOR;
            r_noise_cap             <= vgea_pkg::RST_NOISE_FLOOR_CAP;
            r_floor_gain            <= vgea_pkg::RST_FLOOR_GAIN;
            r_ep_cfg.male_threshold <= vgea_pkg::RST_MALE_THRESHOLD;
            r_ep_cfg.male_needed    <= vgea_pkg::RST_MALE_NEEDED;
            r_ep_cfg.normal_needed  <= vgea_pkg::RST_NORMAL_NEEDED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vgea_pkg::CFG_SILENCE_FLOOR:   r_silence_floor <= i_cfg_wdata;
                vgea_pkg::CFG_NOISE_FLOOR_CAP: r_noise_cap <= i_cfg_wdata;
                vgea_pkg::CFG_FLOOR_GAIN: begin
                    r_floor_gain <= i_cfg_wdata[vgea_pkg::GAIN_W-1:0];
                end
                vgea_pkg::CFG_MALE_THRESHOLD:  r_ep_cfg.male_threshold <= i_cfg_wdata;
                vgea_pkg::CFG_MALE_NEEDED: begin
                    r_ep_cfg.male_needed <= i_cfg_wdata[vgea_pkg::RUN_W-1:0];
                end
                vgea_pkg::CFG_NORMAL_NEEDED: begin
                    r_ep_cfg.normal_needed <= i_cfg_wdata[vgea_pkg::RUN_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // ---- sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Load a fresh beat on a decide step, else drop a beat once taken
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_GATE;
                S_GATE: r_state <= S_DECIDE;
                S_DECIDE: begin
                    // Hold until the output register frees up
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rms  <= s_axis_tdata[RW-1:0];
            r_prob <= s_axis_tdata[RW +: vgea_pkg::PROB_W];
        end
        if (r_state == S_MUL) begin
            r_prod <= PW'(r_floor_gain) * PW'(w_floor);
        end
        if (r_state == S_GATE) begin
            r_gate <= (w_prod_sat < r_silence_floor) ? r_silence_floor : w_prod_sat;
        end
        if (w_step) begin
            r_out_data <= {r_gate, w_ep_result.status, w_voice, w_ep_result.blink};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(vgea_pkg::OUT_TDATA_W - vgea_pkg::OUT_USED_W){1'b0}},
                            r_out_data};

endmodule

`default_nettype wire

// ----- design/vgea_checker.sv -----
// ----------------------------------------------------------------------------
// Voice gate episode alarm: port checker
// Watches the stream ports for result beats that break the class rules.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voice_gate_episode_alarm_defines.svh"

module vgea_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic [vgea_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                             m_axis_tvalid
);

    logic [1:0] w_blink;
    logic       w_voice;
    logic [1:0] w_status;

    assign w_blink  = m_axis_tdata[vgea_pkg::OUT_BLINK_LSB +: 2];
    assign w_voice  = m_axis_tdata[vgea_pkg::OUT_VOICE_LSB];
    assign w_status = m_axis_tdata[vgea_pkg::OUT_STATUS_LSB +: 2];

    // Silence carries no blink and the silence class
    `VGEA_ASSERT_NOW(a_silent_quiet, m_axis_tvalid && !w_voice, (w_blink == vgea_pkg::BLINK_NONE) && (w_status == vgea_pkg::STAT_SILENCE), "silent beat with blink or class")

    // A voiced beat never reports silence
    `VGEA_ASSERT_NOW(a_voiced_class, m_axis_tvalid && w_voice, w_status != vgea_pkg::STAT_SILENCE, "voiced beat reports silence")

    // Red comes only with a confirmed anomaly, green only with a normal class
    `VGEA_ASSERT_NOW(a_blink_class, m_axis_tvalid && (w_blink != vgea_pkg::BLINK_NONE), ((w_blink == vgea_pkg::BLINK_RED) && (w_status == vgea_pkg::STAT_ANOMALY)) || ((w_blink == vgea_pkg::BLINK_GREEN) && (w_status == vgea_pkg::STAT_NORMAL)), "blink does not match class")

    // One window in flight: intake closes after a beat is taken
    `VGEA_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a window is in flight")

endmodule

bind voice_gate_episode_alarm vgea_checker u_vgea_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid)
);

`default_nettype wire

// ----- tb/voice_gate_episode_alarm_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voice gate episode alarm: block-level test
// Streams audio windows into the alarm block and checks every result beat,
// field by field, against an in-bench model of the adaptive gate, the
// debounce counters and the episode machine, or against a hand-read result.
// A short directed table opens, then random voice episodes under several
// register settings, random idling on both streams and forced backpressure.
// ----------------------------------------------------------------------------

module voice_gate_episode_alarm_test;

    localparam int CLK_PERIOD   = 20;
    localparam int HIST_DEPTH   = vgea_pkg::HISTORY_DEPTH_DEF;
    localparam int PIPE_LATENCY = 4;
    localparam int RUN_LIMIT_NS = 4_000_000;

    // Indexes past the last register; the block must ignore writes to them
    localparam logic [vgea_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [vgea_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

    typedef enum logic [1:0] {EP_NONE, EP_REGULAR, EP_ANOMALY} t_episode;

    typedef struct packed {
        logic [1:0]                 blink;
        logic                       voice;
        logic [1:0]                 status;
        logic [vgea_pkg::RMS_W-1:0] gate;
    } t_window_result;

    typedef struct packed {
        logic [vgea_pkg::RMS_W-1:0]  rms;
        logic [vgea_pkg::PROB_W-1:0] prob;
        logic                        known;   // want holds a result read off by hand
        t_window_result              want;
    } t_window;

    localparam t_window_result NO_WANT = '0;

    // Directed windows under the reset settings (gate floor 655, gain 3.0,
    // threshold one half, three windows to confirm either class).
    localparam int DIRECTED_ROWS = 24;
    localparam t_window DIRECTED [DIRECTED_ROWS] = '{
        // silent window at zero level: gate sits on the fixed floor
        '{16'h0000, 16'h0000, 1'b1, '{vgea_pkg::BLINK_NONE, 1'b0, vgea_pkg::STAT_SILENCE,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        // loudest window, certain male: first male window
        '{16'hFFFF, 16'hFFFF, 1'b1, '{vgea_pkg::BLINK_NONE, 1'b1, vgea_pkg::STAT_UNCERTAIN,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        // level exactly on the gate counts as voice; probability one above
        // the threshold counts male
        '{16'd655,  16'h8001, 1'b1, '{vgea_pkg::BLINK_NONE, 1'b1, vgea_pkg::STAT_UNCERTAIN,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        // one below the gate is silence and drops the male run
        '{16'd654,  16'h0000, 1'b1, '{vgea_pkg::BLINK_NONE, 1'b0, vgea_pkg::STAT_SILENCE,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        '{16'hFFFF, 16'hFFFF, 1'b1, '{vgea_pkg::BLINK_NONE, 1'b1, vgea_pkg::STAT_UNCERTAIN,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        '{16'hFFFF, 16'hFFFF, 1'b1, '{vgea_pkg::BLINK_NONE, 1'b1, vgea_pkg::STAT_UNCERTAIN,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        // third male window in a row: red blink, anomaly confirmed
        '{16'hFFFF, 16'hFFFF, 1'b1, '{vgea_pkg::BLINK_RED,  1'b1, vgea_pkg::STAT_ANOMALY,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        // still anomaly, no second blink in the same episode
        '{16'hFFFF, 16'hFFFF, 1'b1, '{vgea_pkg::BLINK_NONE, 1'b1, vgea_pkg::STAT_ANOMALY,
                                      vgea_pkg::RST_SILENCE_FLOOR}},
        // history wraps from here; probability equal to threshold is normal
        '{16'hFFFF, 16'h8000, 1'b0, NO_WANT},
        '{16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        // normal confirmed out of anomaly: no blink
        '{16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        // silence ends the episode, probability ignored
        '{16'h0000, 16'h1234, 1'b0, NO_WANT},
        // three normal windows from no episode: green blink
        '{16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        '{16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        '{16'hFFFF, 16'h0000, 1'b0, NO_WANT},
        // male run out of a normal episode: red is armed again
        '{16'hFFFF, 16'hFFFF, 1'b0, NO_WANT},
        '{16'hFFFF, 16'hFFFF, 1'b0, NO_WANT},
        '{16'hFFFF, 16'hFFFF, 1'b0, NO_WANT},
        // back to normal without a blink
        '{16'hFFFF, 16'h7FFF, 1'b0, NO_WANT},
        '{16'hFFFF, 16'h7FFF, 1'b0, NO_WANT},
        '{16'hFFFF, 16'h7FFF, 1'b0, NO_WANT},
        // and red once more after the confirmed normal voice
        '{16'hFFFF, 16'hC000, 1'b0, NO_WANT},
        '{16'hFFFF, 16'hC000, 1'b0, NO_WANT},
        '{16'hFFFF, 16'hC000, 1'b0, NO_WANT}
    };

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic [vgea_pkg::IN_TDATA_W-1:0]      s_axis_tdata;
    logic                                 s_axis_tvalid;
    logic                                 s_axis_tready;
    logic [vgea_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready;
    logic                                 i_cfg_we;
    logic [vgea_pkg::CFG_IDX_W-1:0]       i_cfg_idx;
    logic [vgea_pkg::CFG_DATA_W-1:0]      i_cfg_wdata;

    voice_gate_episode_alarm u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        // window_rms [15:0], male_probability [31:16]
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // blink_event [1:0], voice_present [2], class_status [4:3],
        // gate_level [20:5], zero [23:21]
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Register copies, kept in step with every write
    logic [vgea_pkg::RMS_W-1:0]  cfg_silence_floor = vgea_pkg::RST_SILENCE_FLOOR;
    logic [vgea_pkg::RMS_W-1:0]  cfg_floor_cap     = vgea_pkg::RST_NOISE_FLOOR_CAP;
    logic [vgea_pkg::GAIN_W-1:0] cfg_floor_gain    = vgea_pkg::RST_FLOOR_GAIN;
    logic [vgea_pkg::PROB_W-1:0] cfg_male_thr      = vgea_pkg::RST_MALE_THRESHOLD;
    logic [vgea_pkg::RUN_W-1:0]  cfg_male_need     = vgea_pkg::RST_MALE_NEEDED;
    logic [vgea_pkg::RUN_W-1:0]  cfg_normal_need   = vgea_pkg::RST_NORMAL_NEEDED;

    // Model state of the gate history and the episode machine
    logic [vgea_pkg::RMS_W-1:0]  rms_hist [HIST_DEPTH];
    int                          hist_fill   = 0;
    int                          hist_wr_pos = 0;
    logic [vgea_pkg::RUN_W-1:0]  male_run    = '0;
    logic [vgea_pkg::RUN_W-1:0]  normal_run  = '0;
    t_episode                    episode     = EP_NONE;

    t_window           window_backlog [$];   // windows not yet offered
    t_window_result    pending_results [$];  // results owed by the block
    t_window           offered;              // window currently on s_axis
    t_window_result    predicted;
    t_window_result    owed;
    logic              window_taken = 1'b0;
    logic              src_hold = 1'b0;
    int                idle_pct = 35;
    int                sink_stall_left = 0;
    int                mismatch_count = 0;

    // Advance the model by one window and return the result it owes.
    function automatic t_window_result gate_and_classify(
        input logic [vgea_pkg::RMS_W-1:0]  rms,
        input logic [vgea_pkg::PROB_W-1:0] prob);
        t_window_result              r;
        logic [vgea_pkg::RMS_W-1:0]  lvl;
        logic [vgea_pkg::PROD_W-1:0] prod;
        int                          i;
        r = '{vgea_pkg::BLINK_NONE, 1'b0, vgea_pkg::STAT_SILENCE, '0};
        rms_hist[hist_wr_pos] = rms;
        hist_wr_pos = (hist_wr_pos == HIST_DEPTH - 1) ? 0 : hist_wr_pos + 1;
        if (hist_fill < HIST_DEPTH) hist_fill++;
        // noise floor: lowest level among the written history entries
        lvl = rms_hist[0];
        for (i = 1; i < hist_fill; i++) begin
            if (rms_hist[i] < lvl) lvl = rms_hist[i];
        end
        if (lvl > cfg_floor_cap) lvl = cfg_floor_cap;
        prod = cfg_floor_gain * lvl;
        prod = prod >> 4;
        r.gate = (prod > vgea_pkg::PROD_W'(vgea_pkg::RMS_MAX)) ? vgea_pkg::RMS_MAX
                                                               : prod[vgea_pkg::RMS_W-1:0];
        if (r.gate < cfg_silence_floor) r.gate = cfg_silence_floor;
        r.voice = (rms >= r.gate);
        if (!r.voice) begin
            male_run   = '0;
            normal_run = '0;
            episode    = EP_NONE;
        end else begin
            if (prob > cfg_male_thr) begin
                if (male_run != '1) male_run++;
                normal_run = '0;
            end else begin
                if (normal_run != '1) normal_run++;
                male_run = '0;
            end
            if (male_run >= cfg_male_need && episode != EP_ANOMALY) begin
                r.blink = vgea_pkg::BLINK_RED;
                episode = EP_ANOMALY;
            end else if (normal_run >= cfg_normal_need) begin
                if (episode == EP_NONE) begin
                    r.blink = vgea_pkg::BLINK_GREEN;
                    episode = EP_REGULAR;
                end else if (episode == EP_ANOMALY) begin
                    episode = EP_REGULAR;
                end
            end
            if (male_run >= cfg_male_need) r.status = vgea_pkg::STAT_ANOMALY;
            else if (male_run != '0)       r.status = vgea_pkg::STAT_UNCERTAIN;
            else                           r.status = vgea_pkg::STAT_NORMAL;
        end
        return r;
    endfunction

    function automatic t_window make_window(input logic [vgea_pkg::RMS_W-1:0] rms,
                                            input logic [vgea_pkg::PROB_W-1:0] prob);
        t_window w;
        w.rms   = rms;
        w.prob  = prob;
        w.known = 1'b0;
        w.want  = NO_WANT;
        return w;
    endfunction

    // Loud level: often full scale, since the high gate settings pass only that
    function automatic logic [vgea_pkg::RMS_W-1:0] loud_level();
        if ($urandom_range(3) == 0) return vgea_pkg::RMS_MAX;
        return vgea_pkg::RMS_W'($urandom_range(32768, 65535));
    endfunction

    function automatic logic [vgea_pkg::PROB_W-1:0] class_prob(input bit is_male);
        if (!is_male) return vgea_pkg::PROB_W'($urandom_range(0, cfg_male_thr));
        if (cfg_male_thr == '1) return '1;
        return vgea_pkg::PROB_W'($urandom_range(cfg_male_thr + 1, 65535));
    endfunction

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Queue voice episodes: mostly runs of one class with random content, now
    // and then broken by a stray window, the rest silence bursts and raw noise.
    task automatic queue_voice_episodes(input int count);
        int                         queued;
        int                         run_len;
        int                         need;
        int                         k;
        bit                         male;
        logic [vgea_pkg::RMS_W-1:0] quiet_top;
        queued = 0;
        need = (cfg_male_need > cfg_normal_need) ? cfg_male_need : cfg_normal_need;
        if (need > 8) need = 8;
        // anything under the fixed floor is silent whatever the history holds
        quiet_top = (cfg_silence_floor == '0) ? '0 : cfg_silence_floor - 1'b1;
        while (queued < count) begin
            case ($urandom_range(9))
                0: begin
                    window_backlog.push_back(make_window(
                        vgea_pkg::RMS_W'($urandom_range(65535)),
                        vgea_pkg::PROB_W'($urandom_range(65535))));
                    queued++;
                end
                1: begin
                    run_len = $urandom_range(1, 3);
                    repeat (run_len) begin
                        window_backlog.push_back(make_window(
                            vgea_pkg::RMS_W'($urandom_range(0, quiet_top)),
                            vgea_pkg::PROB_W'($urandom_range(65535))));
                    end
                    queued += run_len;
                end
                default: begin
                    run_len = $urandom_range(1, need * 2 + 2);
                    male    = ($urandom_range(1) == 1);
                    for (k = 0; k < run_len; k++) begin
                        // a stray window of the other class breaks the run
                        window_backlog.push_back(make_window(loud_level(),
                            class_prob(male ^ ($urandom_range(9) == 0))));
                    end
                    queued += run_len;
                end
            endcase
        end
    endtask

    // Hold until every window is offered and answered, then let the pipe empty
    task automatic settle();
        while (window_backlog.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [vgea_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vgea_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            vgea_pkg::CFG_SILENCE_FLOOR:   cfg_silence_floor = data;
            vgea_pkg::CFG_NOISE_FLOOR_CAP: cfg_floor_cap     = data;
            vgea_pkg::CFG_FLOOR_GAIN:      cfg_floor_gain    = data[vgea_pkg::GAIN_W-1:0];
            vgea_pkg::CFG_MALE_THRESHOLD:  cfg_male_thr      = data;
            vgea_pkg::CFG_MALE_NEEDED:     cfg_male_need     = data[vgea_pkg::RUN_W-1:0];
            vgea_pkg::CFG_NORMAL_NEEDED:   cfg_normal_need   = data[vgea_pkg::RUN_W-1:0];
            default: ;
        endcase
    endtask

    // Load a full register setting while the block is idle
    task automatic load_settings(input logic [vgea_pkg::RMS_W-1:0]  silence_floor,
                                 input logic [vgea_pkg::RMS_W-1:0]  floor_cap,
                                 input logic [vgea_pkg::GAIN_W-1:0] floor_gain,
                                 input logic [vgea_pkg::PROB_W-1:0] male_thr,
                                 input logic [vgea_pkg::RUN_W-1:0]  male_need,
                                 input logic [vgea_pkg::RUN_W-1:0]  normal_need);
        settle();
        write_reg(vgea_pkg::CFG_SILENCE_FLOOR, silence_floor);
        write_reg(vgea_pkg::CFG_NOISE_FLOOR_CAP, floor_cap);
        write_reg(vgea_pkg::CFG_FLOOR_GAIN, vgea_pkg::CFG_DATA_W'(floor_gain));
        write_reg(vgea_pkg::CFG_MALE_THRESHOLD, male_thr);
        write_reg(vgea_pkg::CFG_MALE_NEEDED, vgea_pkg::CFG_DATA_W'(male_need));
        write_reg(vgea_pkg::CFG_NORMAL_NEEDED, vgea_pkg::CFG_DATA_W'(normal_need));
        // junk to the unused indexes last, so aliasing would show up
        write_reg(CFG_UNUSED_A, vgea_pkg::CFG_DATA_W'($urandom_range(65535)));
        write_reg(CFG_UNUSED_B, vgea_pkg::CFG_DATA_W'($urandom_range(65535)));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Input stream: offer the backlog one beat at a time, idling at random.
    // A beat stays on the bus unchanged until the block takes it.
    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        forever begin
            @(negedge i_clk);
            if (!s_axis_tvalid || window_taken) begin
                window_taken = 1'b0;
                if (!src_hold && window_backlog.size() != 0 &&
                    $urandom_range(99) >= idle_pct) begin
                    offered = window_backlog.pop_front();
                    s_axis_tdata  <= {offered.prob, offered.rms};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output stream: random backpressure, plus a long hold-off on request
    // that is counted down here one cycle at a time.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Monitor: check result beats first, then book the window taken this edge,
    // so a beat can never be matched against its own window.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result beat %h with no window outstanding, expected none",
                         $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                owed = pending_results.pop_front();
                compare_field("blink_event", owed.blink,
                              m_axis_tdata[vgea_pkg::OUT_BLINK_LSB +: 2]);
                compare_field("voice_present", owed.voice,
                              m_axis_tdata[vgea_pkg::OUT_VOICE_LSB]);
                compare_field("class_status", owed.status,
                              m_axis_tdata[vgea_pkg::OUT_STATUS_LSB +: 2]);
                compare_field("gate_level", owed.gate,
                              m_axis_tdata[vgea_pkg::OUT_GATE_LSB +: vgea_pkg::RMS_W]);
                compare_field("zero fill", 0,
                              m_axis_tdata[vgea_pkg::OUT_TDATA_W-1:vgea_pkg::OUT_USED_W]);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            window_taken = 1'b1;
            predicted = gate_and_classify(offered.rms, offered.prob);
            pending_results.push_back(offered.known ? offered.want : predicted);
        end
    end

    initial begin
        int row;
        int k;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_wdata = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under the reset settings
        for (row = 0; row < DIRECTED_ROWS; row++) window_backlog.push_back(DIRECTED[row]);

        // Reset values written back explicitly; hold the receiver off long
        // enough to fill the block, then pause the sender until all is answered
        load_settings(vgea_pkg::RST_SILENCE_FLOOR, vgea_pkg::RST_NOISE_FLOOR_CAP,
                      vgea_pkg::RST_FLOOR_GAIN, vgea_pkg::RST_MALE_THRESHOLD,
                      vgea_pkg::RST_MALE_NEEDED, vgea_pkg::RST_NORMAL_NEEDED);
        queue_voice_episodes(60);
        @(posedge i_clk);
        sink_stall_left = 80;
        while (window_backlog.size() > 30) @(posedge i_clk);
        src_hold = 1'b1;
        while (s_axis_tvalid || pending_results.size() != 0) @(posedge i_clk);
        src_hold = 1'b0;

        // Everything zero: gate at zero, every window voiced, zero run
        // thresholds always met
        load_settings('0, '0, '0, '0, '0, '0);
        queue_voice_episodes(30);

        // Everything at full scale: the fixed floor holds the gate at full scale, only
        // full-scale level passes, no window can count male
        load_settings('1, '1, '1, '1, '1, '1);
        queue_voice_episodes(30);

        // Unity gain, no fixed floor: every window voiced. Long single-class
        // runs drive both counters into saturation. No idling for the male run.
        load_settings('0, '1, 8'd16, vgea_pkg::RST_MALE_THRESHOLD, '1, '1);
        idle_pct = 0;
        for (k = 0; k < 256; k++)
            window_backlog.push_back(make_window(vgea_pkg::RMS_W'($urandom_range(65535)),
                                                 class_prob(1'b1)));
        for (k = 0; k < 256; k++)
            window_backlog.push_back(make_window(vgea_pkg::RMS_W'($urandom_range(65535)),
                                                 class_prob(1'b0)));
        while (window_backlog.size() > 256) @(posedge i_clk);
        idle_pct = 35;

        // Two random settings with short confirmation runs
        repeat (2) begin
            load_settings(vgea_pkg::RMS_W'($urandom_range(0, 4000)),
                          vgea_pkg::RMS_W'($urandom_range(65535)),
                          vgea_pkg::GAIN_W'($urandom_range(255)),
                          vgea_pkg::PROB_W'($urandom_range(65535)),
                          vgea_pkg::RUN_W'($urandom_range(1, 6)),
                          vgea_pkg::RUN_W'($urandom_range(1, 6)));
            queue_voice_episodes(30);
        end

        settle();
        if (mismatch_count == 0) begin
            $display("voice_gate_episode_alarm test passed");
        end else begin
            $display("voice_gate_episode_alarm test failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("voice_gate_episode_alarm test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/vgea_pkg.sv
design/vgea_cell.sv
design/vgea_episode.sv
design/voice_gate_episode_alarm.sv
design/vgea_checker.sv
tb/voice_gate_episode_alarm_test.sv
